// File: rtl/spq_pkg.sv
// Shared constants and types for the stable priority queue.
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_REMOVED  = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } sts_t;

endpackage

// File: rtl/spq_ctrl.sv
// Controller state machine: takes one word, then runs it through the datapath.
module spq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  spq_pkg::sts_t sts,
    output spq_pkg::cmd_t cmd
);
    import spq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // wait while the previous result still sits unclaimed
                if (!sts.out_busy)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/spq_datapath.sv
// Datapath: sorted slot array with per-slot compares, item and result registers.
module spq_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  spq_pkg::cmd_t cmd,
    output spq_pkg::sts_t sts,
    input  logic          opcode,
    input  logic [7:0]    priority_req,
    input  logic [15:0]   tag,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [1:0]    status,
    output logic [7:0]    out_priority,
    output logic [15:0]   out_tag
);
    import spq_pkg::*;

    logic             op_reg;
    logic [7:0]       pr_reg;
    logic [15:0]      tag_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       slot_pr_reg  [DEPTH];
    logic [7:0]       slot_pr_next [DEPTH];
    logic [15:0]      slot_tag_reg [DEPTH];
    logic [15:0]      slot_tag_next[DEPTH];
    logic             ov_reg;
    logic             ov_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic [7:0]       opr_reg;
    logic [7:0]       opr_next;
    logic [15:0]      otag_reg;
    logic [15:0]      otag_next;
    logic [DEPTH-1:0] le;
    logic             full;
    logic             empty;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            le[i] = (CNT_W'(i) < count_reg) && (slot_pr_reg[i] <= pr_reg);
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        ov_next     = ov_reg;
        status_next = status_reg;
        opr_next    = opr_reg;
        otag_next   = otag_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_pr_next[i]  = slot_pr_reg[i];
            slot_tag_next[i] = slot_tag_reg[i];
        end
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        if (cmd.exec)
        begin
            ov_next   = 1'b1;
            opr_next  = '0;
            otag_next = '0;
            if (op_reg == OP_INSERT)
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_INSERTED;
                    count_next  = count_reg + 1'b1;
                    // new entry lands after the last slot with priority <= new
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (!le[i])
                        begin
                            if (i == 0 || le[(i == 0) ? 0 : i - 1])
                            begin
                                slot_pr_next[i]  = pr_reg;
                                slot_tag_next[i] = tag_reg;
                            end
                            else
                            begin
                                slot_pr_next[i]  = slot_pr_reg[(i == 0) ? 0 : i - 1];
                                slot_tag_next[i] = slot_tag_reg[(i == 0) ? 0 : i - 1];
                            end
                        end
                    end
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    status_next = ST_REMOVED;
                    opr_next    = slot_pr_reg[0];
                    otag_next   = slot_tag_reg[0];
                    count_next  = count_reg - 1'b1;
                    for (int i = 0; i < DEPTH - 1; i++)
                    begin
                        slot_pr_next[i]  = slot_pr_reg[i + 1];
                        slot_tag_next[i] = slot_tag_reg[i + 1];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            pr_reg  <= priority_req;
            tag_reg <= tag;
        end
        status_reg <= status_next;
        opr_reg    <= opr_next;
        otag_reg   <= otag_next;
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_pr_reg[i]  <= slot_pr_next[i];
            slot_tag_reg[i] <= slot_tag_next[i];
        end
    end

    assign sts.out_busy = ov_reg && out_stall;
    assign out_valid    = ov_reg;
    assign status       = status_reg;
    assign out_priority = opr_reg;
    assign out_tag      = otag_reg;

endmodule

// File: rtl/stable_priority_queue.sv
// Top level of the stable priority queue: controller plus datapath.
//
//  channel  handshake            word
//  in       in_valid / in_stall  opcode, priority_req, tag
//  out      out_valid / out_stall status, out_priority, out_tag
//
// Each word goes through two steps: a capture step, then the parallel
// compare-and-shift over all slots, which writes the result register.
// A new word is taken while the last result still waits; the shift step
// holds off only while the result register is full and stalled.
// Reset empties the queue at once; slot contents are never cleared.
module stable_priority_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [7:0]  priority_req,
    input  logic [15:0] tag,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [7:0]  out_priority,
    output logic [15:0] out_tag
);
    import spq_pkg::*;

    cmd_t cmd;
    sts_t sts;

    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    spq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .opcode       (opcode),
        .priority_req (priority_req),
        .tag          (tag),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .out_priority (out_priority),
        .out_tag      (out_tag)
    );

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the stable priority queue: directed and random traffic, in-order result check.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int CALM_START  = 2000;
    localparam int CALM_END    = 4500;
    localparam int DRAIN_WAIT  = 20;
    localparam int RANDOM_WORDS = 1530;

    typedef struct packed {
        logic        op;
        logic [7:0]  prio;
        logic [15:0] tag;
    } word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  prio;
        logic [15:0] tag;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic [7:0]  priority_req;
    logic [15:0] tag;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [7:0]  out_priority;
    logic [15:0] out_tag;

    word_t   pending_words[$];
    result_t expected_results[$];

    logic [7:0]  held_prio [DEPTH];
    logic [15:0] held_tag  [DEPTH];
    int          held_count = 0;

    int      cycle_count = 0;
    bit      in_taken = 0;
    bit      any_error = 0;
    word_t   next_word;
    result_t want;

    stable_priority_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .priority_req (priority_req),
        .tag          (tag),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .out_priority (out_priority),
        .out_tag      (out_tag)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Sorted insert behind equal priorities; remove takes slot 0.
    function automatic result_t serve_word(input word_t w);
        result_t r;
        int      pos;
        int      i;
        r = '{ST_INSERTED, 8'd0, 16'd0};
        if (w.op == OP_INSERT)
        begin
            if (held_count >= DEPTH)
                r.status = ST_FULL;
            else
            begin
                pos = 0;
                while (pos < held_count && held_prio[pos] <= w.prio)
                    pos++;
                for (i = held_count; i > pos; i--)
                begin
                    held_prio[i] = held_prio[i - 1];
                    held_tag[i]  = held_tag[i - 1];
                end
                held_prio[pos] = w.prio;
                held_tag[pos]  = w.tag;
                held_count++;
            end
        end
        else if (held_count == 0)
            r.status = ST_EMPTY;
        else
        begin
            r = '{ST_REMOVED, held_prio[0], held_tag[0]};
            for (i = 0; i + 1 < held_count; i++)
            begin
                held_prio[i] = held_prio[i + 1];
                held_tag[i]  = held_tag[i + 1];
            end
            held_count--;
        end
        return r;
    endfunction

    function automatic bit take_break();
        return (cycle_count < CALM_START || cycle_count > CALM_END)
            && $urandom_range(99) < 10;
    endfunction

    function automatic void push_word(input logic op, input logic [7:0] p,
                                      input logic [15:0] t);
        pending_words.push_back('{op, p, t});
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= take_break();
            if (!in_valid || in_taken)
            begin
                if (pending_words.size() != 0 && !take_break())
                begin
                    next_word = pending_words.pop_front();
                    in_valid     <= 1'b1;
                    opcode       <= next_word.op;
                    priority_req <= next_word.prio;
                    tag          <= next_word.tag;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                expected_results.push_back(serve_word('{opcode, priority_req, tag}));
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected word: status %0d priority %0d tag %0h",
                           status, out_priority, out_tag);
                    any_error = 1'b1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        any_error = 1'b1;
                    end
                    if (out_priority !== want.prio)
                    begin
                        $error("out_priority: expected %0d, got %0d",
                               want.prio, out_priority);
                        any_error = 1'b1;
                    end
                    if (out_tag !== want.tag)
                    begin
                        $error("out_tag: expected %0h, got %0h", want.tag, out_tag);
                        any_error = 1'b1;
                    end
                end
            end
        end
    end

    initial
    begin
        int    k;
        int    made;
        int    phase_len;
        int    insert_pct;
        int    prio_mode;
        logic  op;
        logic [7:0] p;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        out_stall    = 1'b0;
        opcode       = OP_INSERT;
        priority_req = 8'd0;
        tag          = 16'd0;

        // remove on empty, extremes, equal priorities, fill to full, drop, drain a few
        push_word(OP_REMOVE, 8'hFF, 16'hFFFF);
        push_word(OP_INSERT, 8'd255, 16'h0000);
        push_word(OP_INSERT, 8'd0, 16'hFFFF);
        push_word(OP_INSERT, 8'd0, 16'h00A5);
        push_word(OP_INSERT, 8'd255, 16'h5A00);
        push_word(OP_INSERT, 8'd128, 16'h8001);
        for (k = 5; k < DEPTH; k++)
            push_word(OP_INSERT, 8'(k * 17), 16'(k * 4097));
        push_word(OP_INSERT, 8'd1, 16'hBEEF);
        repeat (3)
            push_word(OP_REMOVE, 8'h00, 16'h0000);

        made = 0;
        while (made < RANDOM_WORDS)
        begin
            phase_len  = $urandom_range(60, 30);
            case ($urandom_range(3))
                0: insert_pct = 85;
                1: insert_pct = 15;
                2: insert_pct = 50;
                default: insert_pct = $urandom_range(100);
            endcase
            prio_mode = $urandom_range(2);
            repeat (phase_len)
            begin
                op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
                case (prio_mode)
                    0: p = 8'($urandom);
                    1: p = 8'($urandom_range(3));
                    default: p = $urandom_range(1) ? 8'd255 : 8'd0;
                endcase
                push_word(op, p, 16'($urandom));
                made++;
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (!any_error)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
